@@ src/key_value_command_frame_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// key value command frame parser: assertion macros
// shared property wrappers, sampled on clock and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define KEY_VALUE_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define KVCFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kvcfp: same-cycle check failed");

// next-cycle implication
`define KVCFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kvcfp: next-cycle check failed");

`endif

@@ src/kvcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// kvcfp_pkg
// types, character codes and key phase codes for the command frame parser
// ----------------------------------------------------------------------------
package kvcfp_pkg;

   localparam logic [7:0] MAX_LEN = 8'd64;

   // per-key parse phase
   localparam logic [2:0] PH_UNSEEN = 3'd0;
   localparam logic [2:0] PH_SKIP   = 3'd1;
   localparam logic [2:0] PH_LEAD   = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   localparam logic [7:0] CH_START = 8'h21;  // '!'
   localparam logic [7:0] CH_END   = 8'h23;  // '#'
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_KEY_S = 8'h53;
   localparam logic [7:0] CH_KEY_F = 8'h46;
   localparam logic [7:0] CH_KEY_A = 8'h41;
   localparam logic [7:0] CH_KEY_O = 8'h4f;
   localparam logic [7:0] CH_KEY_W = 8'h57;
   localparam logic [7:0] CH_SINE  = 8'h53;
   localparam logic [7:0] CH_TRI   = 8'h54;
   localparam logic [7:0] CH_SQR   = 8'h43;
   localparam logic [7:0] CH_SAW   = 8'h44;

   localparam logic [2:0] WAVE_SINE    = 3'd0;
   localparam logic [2:0] WAVE_TRI     = 3'd1;
   localparam logic [2:0] WAVE_SQUARE  = 3'd2;
   localparam logic [2:0] WAVE_SAW     = 3'd3;
   localparam logic [2:0] WAVE_UNKNOWN = 3'd4;

   localparam logic [15:0] MAG_CAP = 16'd32768;
   localparam logic [15:0] POS_MAX = 16'd32767;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } kvcfp_req_type;

   typedef struct packed {
      logic              frame_valid;
      logic [2:0]        waveform;
      logic signed [15:0] frequency;
      logic signed [15:0] amplitude;
      logic signed [15:0] offset;
      logic              save_request;
   } kvcfp_rsp_type;

   // one accepted beat as seen by a key parser
   typedef struct packed {
      logic       accept;
      logic       last;
      logic [7:0] byte_value;
   } kvcfp_beat_type;

   // key parser status, after the current beat is taken into account
   typedef struct packed {
      logic               seen;
      logic signed [15:0] value;
      logic               nonzero;
   } kvcfp_key_result_type;

   function automatic logic [2:0] shape_of(input logic [7:0] c);
      logic [2:0] code;
      case (c)
         CH_SINE: code = WAVE_SINE;
         CH_TRI:  code = WAVE_TRI;
         CH_SQR:  code = WAVE_SQUARE;
         CH_SAW:  code = WAVE_SAW;
         default: code = WAVE_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

@@ src/kvcfp_num_key.sv @@
// ----------------------------------------------------------------------------
// kvcfp_num_key
// one numeric key: waits for its letter, skips a byte, then reads a decimal
// value with leading blanks and optional sign, saturated to 16-bit signed
// ----------------------------------------------------------------------------
module kvcfp_num_key
   import kvcfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  kvcfp_beat_type       beat,
   input  logic [7:0]           key_letter,
   output kvcfp_key_result_type result
);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        is_digit;
   logic        is_blank;
   logic [18:0] mag_x10;
   logic [15:0] mag_sat;
   logic [15:0] mag_pos;

   assign is_digit = beat.byte_value inside {[8'h30:8'h39]};
   assign is_blank = beat.byte_value inside {8'h20, [8'h09:8'h0d]};

   // mag * 10 + digit, capped just above the positive range
   assign mag_x10 = ({3'b000, mag_ff} << 3) + ({3'b000, mag_ff} << 1)
                    + {15'd0, beat.byte_value[3:0]};
   assign mag_sat = (mag_x10 > {3'b000, MAG_CAP}) ? MAG_CAP : mag_x10[15:0];

   always_comb begin
      phase_in = phase_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      case (phase_ff)
         PH_UNSEEN: begin
            if (beat.byte_value == key_letter) phase_in = PH_SKIP;
         end
         PH_SKIP: begin
            phase_in = PH_LEAD;
         end
         PH_LEAD: begin
            if (is_blank) begin
               phase_in = PH_LEAD;
            end else if (beat.byte_value == CH_PLUS) begin
               phase_in = PH_DIGITS;
            end else if (beat.byte_value == CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_DIGITS;
            end else if (is_digit) begin
               mag_in   = mag_sat;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (is_digit) mag_in = mag_sat;
            else phase_in = PH_DONE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   assign mag_pos = (mag_in > POS_MAX) ? POS_MAX : mag_in;

   assign result.seen    = (phase_in != PH_UNSEEN);
   assign result.value   = neg_in ? $signed(16'd0 - mag_in) : $signed(mag_pos);
   assign result.nonzero = (mag_in != 16'd0);

   // the last beat of a frame leaves the key ready for the next frame
   always_ff @(posedge clock) begin
      if (reset || (beat.accept && beat.last)) begin
         phase_ff <= PH_UNSEEN;
         mag_ff   <= 16'd0;
         neg_ff   <= 1'b0;
      end else if (beat.accept) begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
      end
   end

endmodule

@@ src/key_value_command_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// key_value_command_frame_parser_top
// parses a '!' ... '#' command frame byte by byte and reports the waveform,
// frequency, amplitude, offset and save request on the final byte
// ----------------------------------------------------------------------------
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------
//  request | req_valid req_stall req_data   | one frame character
//  result  | rsp_valid rsp_stall rsp_data   | one parsed frame, on last byte
//
//  one byte is accepted every cycle while req_stall is low; the result appears
//  the cycle after the last byte, from a single output register
//  rsp_data is set by that register; the x10 digit add and the
//  saturation sit in the combinational path ahead of it
//  reset clears the frame state and empties the output register
//  req_stall rises only while a result is held and rsp_stall is high
// ----------------------------------------------------------------------------
`include "key_value_command_frame_parser_top_defines.svh"

module key_value_command_frame_parser_top
   import kvcfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  kvcfp_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output kvcfp_rsp_type rsp_data
);

   logic          accept;
   logic          frame_end;
   kvcfp_beat_type beat;

   logic [7:0]    count_ff, count_in;
   logic          too_long_ff, too_long_in;
   logic          start_seen_ff, start_seen_in;
   logic [2:0]    phase_s_ff, phase_s_in;
   logic [2:0]    shape_ff, shape_in;

   kvcfp_key_result_type freq_res, ampl_res, offs_res, save_res;

   logic          frame_ok;
   kvcfp_rsp_type rsp_in;
   kvcfp_rsp_type rsp_data_ff;
   logic          rsp_valid_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign frame_end = accept && req_data.last_byte;

   assign beat.accept     = accept;
   assign beat.last       = req_data.last_byte;
   assign beat.byte_value = req_data.byte_value;

   // frame length and start marker
   always_comb begin
      start_seen_in = start_seen_ff;
      too_long_in   = too_long_ff;
      count_in      = count_ff;
      if (count_ff == 8'd0 && !too_long_ff) start_seen_in = (req_data.byte_value == CH_START);
      if (count_ff >= MAX_LEN) too_long_in = 1'b1;
      else count_in = count_ff + 8'd1;
   end

   // waveform key
   always_comb begin
      phase_s_in = phase_s_ff;
      shape_in   = shape_ff;
      case (phase_s_ff)
         PH_UNSEEN: begin
            if (req_data.byte_value == CH_KEY_S) phase_s_in = PH_SKIP;
         end
         PH_SKIP: begin
            phase_s_in = PH_LEAD;
         end
         PH_LEAD: begin
            shape_in   = shape_of(req_data.byte_value);
            phase_s_in = PH_DONE;
         end
         default: begin
            phase_s_in = phase_s_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         count_ff      <= 8'd0;
         too_long_ff   <= 1'b0;
         start_seen_ff <= 1'b0;
         phase_s_ff    <= PH_UNSEEN;
         shape_ff      <= WAVE_UNKNOWN;
      end else if (accept) begin
         count_ff      <= count_in;
         too_long_ff   <= too_long_in;
         start_seen_ff <= start_seen_in;
         phase_s_ff    <= phase_s_in;
         shape_ff      <= shape_in;
      end
   end

   kvcfp_num_key u_freq (
      .clock(clock), .reset(reset), .beat(beat), .key_letter(CH_KEY_F), .result(freq_res)
   );
   kvcfp_num_key u_ampl (
      .clock(clock), .reset(reset), .beat(beat), .key_letter(CH_KEY_A), .result(ampl_res)
   );
   kvcfp_num_key u_offs (
      .clock(clock), .reset(reset), .beat(beat), .key_letter(CH_KEY_O), .result(offs_res)
   );
   kvcfp_num_key u_save (
      .clock(clock), .reset(reset), .beat(beat), .key_letter(CH_KEY_W), .result(save_res)
   );

   assign frame_ok = !too_long_in && start_seen_in && (req_data.byte_value == CH_END)
                     && (phase_s_in != PH_UNSEEN) && freq_res.seen && ampl_res.seen
                     && offs_res.seen && save_res.seen;

   always_comb begin
      rsp_in.frame_valid  = frame_ok;
      rsp_in.waveform     = frame_ok ? shape_in : WAVE_UNKNOWN;
      rsp_in.frequency    = frame_ok ? freq_res.value : 16'sd0;
      rsp_in.amplitude    = frame_ok ? ampl_res.value : 16'sd0;
      rsp_in.offset       = frame_ok ? offs_res.value : 16'sd0;
      rsp_in.save_request = frame_ok && save_res.nonzero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `KVCFP_ASSERT_NEXT(a_last_gives_result, frame_end, rsp_valid_ff)
   `KVCFP_ASSERT_NEXT(a_no_spurious_result,
      accept && !req_data.last_byte && !rsp_valid_ff, !rsp_valid_ff)
   `KVCFP_ASSERT_NOW(a_invalid_frame_zeroed, rsp_valid_ff && !rsp_data_ff.frame_valid,
      rsp_data_ff.waveform == WAVE_UNKNOWN && rsp_data_ff.frequency == 16'sd0
      && rsp_data_ff.amplitude == 16'sd0 && rsp_data_ff.offset == 16'sd0
      && !rsp_data_ff.save_request)
   `KVCFP_ASSERT_NEXT(a_frame_state_cleared, frame_end,
      count_ff == 8'd0 && !start_seen_ff && !too_long_ff && phase_s_ff == PH_UNSEEN)
   `KVCFP_ASSERT_NOW(a_count_bounded, 1'b1, count_ff <= MAX_LEN)

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: command frame parser testbench
// sends '!' ... '#' frames one character per beat with random gaps and
// result stalls, tracks the frame state alongside the block and checks every
// parsed frame field by field against the tracked state
// ----------------------------------------------------------------------------
module tb_top;
   import kvcfp_pkg::*;

   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;

   localparam int KEY_S  = 0;
   localparam int KEY_F  = 1;
   localparam int KEY_A  = 2;
   localparam int KEY_O  = 3;
   localparam int KEY_W  = 4;
   localparam int NO_KEY = -1;

   localparam int RANDOM_BEATS = 200;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   kvcfp_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   kvcfp_rsp_type rsp_data;

   // tracked frame state
   logic [7:0]    seen_bytes;
   logic          overlong;
   logic          bang_seen;
   logic [2:0]    phase [5];
   logic [15:0]   mag [4];
   logic          neg [4];
   logic [2:0]    shape;

   kvcfp_rsp_type frames_due [$];
   logic [7:0]    frame_buf [$];
   logic          calm = 1'b0;
   int            mismatches = 0;
   int            results_seen = 0;
   int            beats_sent = 0;

   key_value_command_frame_parser_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_frame();
      seen_bytes = '0;
      overlong   = 1'b0;
      bang_seen  = 1'b0;
      for (int k = 0; k < 5; k++) phase[k] = PH_UNSEEN;
      for (int v = 0; v < 4; v++) begin
         mag[v] = '0;
         neg[v] = 1'b0;
      end
      shape = WAVE_UNKNOWN;
   endfunction

   function automatic logic signed [15:0] saturated_value(input int v);
      if (neg[v]) return 16'h0000 - mag[v];
      return (mag[v] > POS_MAX) ? POS_MAX : mag[v];
   endfunction

   function automatic void parse_char(input logic [7:0] b, input logic last);
      kvcfp_rsp_type r;
      logic          ok;
      logic          digit;
      logic          blank;
      logic [7:0]    letter;
      int            m;
      if (seen_bytes == 0 && !overlong) bang_seen = (b == CH_START);
      if (seen_bytes >= MAX_LEN) overlong = 1'b1;
      else seen_bytes++;

      case (phase[KEY_S])
         PH_UNSEEN: if (b == CH_KEY_S) phase[KEY_S] = PH_SKIP;
         PH_SKIP:   phase[KEY_S] = PH_LEAD;
         PH_LEAD: begin
            case (b)
               CH_SINE: shape = WAVE_SINE;
               CH_TRI:  shape = WAVE_TRI;
               CH_SQR:  shape = WAVE_SQUARE;
               CH_SAW:  shape = WAVE_SAW;
               default: shape = WAVE_UNKNOWN;
            endcase
            phase[KEY_S] = PH_DONE;
         end
         default: ;
      endcase

      digit = (b >= CH_ZERO && b <= CH_NINE);
      blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
      m     = 0;
      for (int k = KEY_F; k <= KEY_W; k++) begin
         case (k)
            KEY_F:   letter = CH_KEY_F;
            KEY_A:   letter = CH_KEY_A;
            KEY_O:   letter = CH_KEY_O;
            default: letter = CH_KEY_W;
         endcase
         // in lead phase a digit both starts the number and moves to digits
         if (digit && (phase[k] == PH_LEAD || phase[k] == PH_DIGITS)) begin
            m = mag[k-1] * 10 + (b - CH_ZERO);
            mag[k-1] = (m > MAG_CAP) ? MAG_CAP : 16'(m);
         end
         case (phase[k])
            PH_UNSEEN: if (b == letter) phase[k] = PH_SKIP;
            PH_SKIP:   phase[k] = PH_LEAD;
            PH_LEAD: begin
               if (b == CH_MINUS) neg[k-1] = 1'b1;
               if (b == CH_PLUS || b == CH_MINUS || digit) phase[k] = PH_DIGITS;
               else if (!blank) phase[k] = PH_DONE;
            end
            PH_DIGITS: if (!digit) phase[k] = PH_DONE;
            default: ;
         endcase
      end

      if (last) begin
         ok = !overlong && bang_seen && (b == CH_END);
         for (int k = 0; k < 5; k++) if (phase[k] == PH_UNSEEN) ok = 1'b0;
         r = '0;
         r.waveform = WAVE_UNKNOWN;
         if (ok) begin
            r.frame_valid  = 1'b1;
            r.waveform     = shape;
            r.frequency    = saturated_value(KEY_F - 1);
            r.amplitude    = saturated_value(KEY_A - 1);
            r.offset       = saturated_value(KEY_O - 1);
            r.save_request = (mag[KEY_W - 1] != 0);
         end
         frames_due.push_back(r);
         clear_frame();
      end
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_beat(input logic [7:0] b, input logic last);
      int gap;
      gap = (!calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_char(b, last);
      beats_sent++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < frame_buf.size(); i++)
         send_beat(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic load_text(input string s);
      frame_buf.delete();
      for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
   endtask

   task automatic send_frame(input string s);
      load_text(s);
      send_buffer();
   endtask

   // grow the frame to len bytes with random filler ahead of its final byte
   task automatic pad_to(input int len);
      logic [7:0] tail;
      tail = frame_buf.pop_back();
      while (frame_buf.size() < len - 1) frame_buf.push_back(any_char());
      frame_buf.push_back(tail);
   endtask

   function automatic logic [7:0] any_char();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] blank_char();
      int sel;
      sel = $urandom_range(0, 5);
      return (sel == 0) ? CH_SPACE : 8'(8 + sel);
   endfunction

   function automatic logic [7:0] shape_char();
      case ($urandom_range(0, 4))
         0:       return CH_SINE;
         1:       return CH_TRI;
         2:       return CH_SQR;
         3:       return CH_SAW;
         default: return any_char();
      endcase
   endfunction

   task automatic add_number();
      int n;
      frame_buf.push_back(($urandom_range(0, 1) == 0) ? CH_EQUAL : any_char());
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) frame_buf.push_back(blank_char());
      case ($urandom_range(0, 3))
         0:       frame_buf.push_back(CH_PLUS);
         1:       frame_buf.push_back(CH_MINUS);
         default: ;
      endcase
      // mostly short numbers, now and then long enough to saturate
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
      repeat (n) frame_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic build_frame(input int drop_key);
      int order [5];
      int j;
      int t;
      frame_buf.delete();
      frame_buf.push_back(CH_START);
      for (int k = 0; k < 5; k++) order[k] = k;
      for (int k = 4; k > 0; k--) begin
         j        = $urandom_range(0, k);
         t        = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      for (int k = 0; k < 5; k++) begin
         if (order[k] != drop_key) begin
            if ($urandom_range(0, 7) == 0) frame_buf.push_back(any_char());
            case (order[k])
               KEY_S: begin
                  frame_buf.push_back(CH_KEY_S);
                  frame_buf.push_back(($urandom_range(0, 1) == 0) ? CH_EQUAL : any_char());
                  frame_buf.push_back(shape_char());
               end
               KEY_F: begin
                  frame_buf.push_back(CH_KEY_F);
                  add_number();
               end
               KEY_A: begin
                  frame_buf.push_back(CH_KEY_A);
                  add_number();
               end
               KEY_O: begin
                  frame_buf.push_back(CH_KEY_O);
                  add_number();
               end
               default: begin
                  frame_buf.push_back(CH_KEY_W);
                  add_number();
               end
            endcase
         end
      end
      frame_buf.push_back(CH_END);
   endtask

   task automatic break_frame();
      int         n;
      logic [7:0] junk;
      case ($urandom_range(0, 3))
         0: frame_buf[0] = any_char();
         1: frame_buf[frame_buf.size() - 1] = any_char();
         2: pad_to($urandom_range(60, 70));
         default: begin
            n = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > n) junk = frame_buf.pop_back();
         end
      endcase
   endtask

   task automatic noise_frame();
      int len;
      len = $urandom_range(1, 80);
      frame_buf.delete();
      repeat (len) frame_buf.push_back(any_char());
      if ($urandom_range(0, 1) == 0) begin
         frame_buf[0]                   = CH_START;
         frame_buf[frame_buf.size() - 1] = CH_END;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_waveforms();
      send_frame("!S=SF=1A=2O=3W=1#");
      send_frame("!S=TF=10A=20O=30W=0#");
      send_frame("!SxCF=0A=0O=0W=0#");
      send_frame("!S=DF=5A=5O=5W=5#");
      // extreme byte values as skip and shape characters
      load_text("!S=SF=1A=1O=1W=1#");
      frame_buf[2] = 8'h01;
      frame_buf[3] = 8'hff;
      send_buffer();
   endtask

   task automatic test_number_forms();
      send_frame("!S=SF=32767A=32768O=-32768W=1#");
      send_frame("!S=TF=99999A=-99999O=+12W=0#");
      send_frame("!S=CF= \t\n42A=-O=+W=007#");
      send_frame("!S=DF=x5A=00000000012O=-0W=-3#");
   endtask

   task automatic test_framing();
      send_frame("?S=SF=1A=1O=1W=1#");
      send_frame("!S=SF=1A=1O=1W=1x");
      send_frame("!S=SF=1A=1O=1#");
      send_frame("#");
      send_frame("!");
      load_text("!S=SF=1A=1O=1W=1#");
      pad_to(int'(MAX_LEN));
      send_buffer();
      load_text("!S=SF=1A=1O=1W=1#");
      pad_to(int'(MAX_LEN) + 1);
      send_buffer();
   endtask

   task automatic test_truncated_frames();
      send_frame("!F=1A=2O=3W=4S#");
      send_frame("!F=1A=2O=3S=TW#");
      send_frame("!S=TF=5A=6O=7W=#");
      send_frame("!SFAOW#");
   endtask

   task automatic test_key_overlap();
      send_frame("!S=AF=FA=3O=WW=9#");
      send_frame("!SOF=1A=2O=3W=4#");
      send_frame("!F=12S=DF=99A=1A=7O=1O=2W=0W=1#");
   endtask

   task automatic test_random_frames();
      int first;
      first = beats_sent;
      while (beats_sent - first < RANDOM_BEATS) begin
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: noise_frame();
            1: build_frame($urandom_range(KEY_S, KEY_W));
            2: begin
               build_frame(NO_KEY);
               break_frame();
            end
            default: build_frame(NO_KEY);
         endcase
         send_buffer();
      end
      calm = 1'b0;
   endtask

   // ---------------------------------------------------------------- result side

   initial begin
      int n;
      forever begin
         n = calm ? 0 : (($urandom_range(0, 1) == 0) ? $urandom_range(1, 16) : 0);
         rsp_stall <= (n > 0);
         @(posedge clock);
         // hold the stall, counting n down only in cycles in which a result is waiting
         while (!(rsp_valid && !rsp_stall)) begin
            if (rsp_valid && n > 0) begin
               n--;
               if (n == 0) rsp_stall <= 1'b0;
            end
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      kvcfp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result beat %0d arrived with no frame pending", results_seen);
         end else begin
            want = frames_due.pop_front();
            if (rsp_data.frame_valid  !== want.frame_valid ||
                rsp_data.waveform     !== want.waveform    ||
                rsp_data.frequency    !== want.frequency   ||
                rsp_data.amplitude    !== want.amplitude   ||
                rsp_data.offset       !== want.offset      ||
                rsp_data.save_request !== want.save_request) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result beat %0d exp: valid=%0b wave=%0d f=%0d a=%0d o=%0d w=%0b",
                           results_seen, want.frame_valid, want.waveform,
                           $signed(want.frequency), $signed(want.amplitude),
                           $signed(want.offset), want.save_request);
                  $display("result beat %0d got: valid=%0b wave=%0d f=%0d a=%0d o=%0d w=%0b",
                           results_seen, rsp_data.frame_valid, rsp_data.waveform,
                           $signed(rsp_data.frequency), $signed(rsp_data.amplitude),
                           $signed(rsp_data.offset), rsp_data.save_request);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      clear_frame();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_waveforms();
      test_number_forms();
      test_framing();
      test_truncated_frames();
      test_key_overlap();
      test_random_frames();
      wait_drained();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/kvcfp_pkg.sv
src/kvcfp_num_key.sv
src/key_value_command_frame_parser_top.sv
dv/tb_top.sv
